// ----- rtl/core/two_side_slit_controller_macros.svh -----
// Assertion macros for the two-sided slit controller.
`ifndef TWO_SIDE_SLIT_CONTROLLER_MACROS_SVH
`define TWO_SIDE_SLIT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, reset masked.
`define TSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tssc assertion failed");
// Next-cycle implication, reset masked.
`define TSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tssc assertion failed");
`else
`define TSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/tssc_pkg.sv -----
// Types and constants for the slit controller.
package tssc_pkg;

	localparam int TSSC_QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		ST_ERROR   = 3'd0,
		ST_OPENING = 3'd1,
		ST_PARTLY  = 3'd2,
		ST_FULLY   = 3'd3,
		ST_CLOSING = 3'd4,
		ST_CLOSED  = 3'd5
	} slit_st_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0,
		OP_CLOSE = 3'd1,
		OP_STOP  = 3'd2,
		OP_REPLY = 3'd3,
		OP_TICK  = 3'd4
	} op_t;

	localparam logic [1:0] RC_FAIL   = 2'd0;
	localparam logic [1:0] RC_STATUS = 2'd1;

	localparam logic [7:0] BYTE_MOVING = 8'h30;
	localparam logic [7:0] BYTE_FULLY  = 8'h31;

	localparam logic [3:0]  FAIL_LIMIT_RST = 4'd3;
	localparam logic [3:0]  FAIL_CNT_MAX   = 4'd15;
	localparam logic [15:0] SEC_MAX        = 16'hFFFF;

	localparam logic [15:0] COIL_R_OPEN  = 16'h0108;
	localparam logic [15:0] COIL_R_CLOSE = 16'h0308;
	localparam logic [15:0] COIL_L_OPEN  = 16'h0008;
	localparam logic [15:0] COIL_L_CLOSE = 16'h0208;

	// index of each side in the state arrays
	localparam int SIDE_R   = 0;
	localparam int SIDE_L   = 1;
	localparam int SIDE_ALL = 2;

	typedef struct packed {
		logic        switch_valid;
		logic [15:0] switch_address;
		logic        switch_on;
		slit_st_t    overall_state;
		slit_st_t    left_state;
		slit_st_t    right_state;
		logic        rainy;
		logic        queue_overflow;
		logic        last;
	} result_t;

	function automatic logic [15:0] coil_addr(input logic left, input logic open);
		if (left) begin
			return open ? COIL_L_OPEN : COIL_L_CLOSE;
		end
		return open ? COIL_R_OPEN : COIL_R_CLOSE;
	endfunction

endpackage

// ----- rtl/core/tssc_req_if.sv -----
// Request channel: open/close/stop requests, controller replies and ticks.
interface tssc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [15:0] open_period;
	logic [1:0]  reply_code;
	logic [7:0]  right_byte;
	logic [7:0]  left_byte;
	logic [7:0]  rain_byte;

	modport source (
		output valid, operation, open_period, reply_code, right_byte, left_byte, rain_byte,
		input  ready
	);
	modport sink (
		input  valid, operation, open_period, reply_code, right_byte, left_byte, rain_byte,
		output ready
	);
endinterface

// ----- rtl/core/tssc_rsp_if.sv -----
// Response channel: switch commands and slit status.
interface tssc_rsp_if;
	logic        valid;
	logic        ready;
	logic        switch_valid;
	logic [15:0] switch_address;
	logic        switch_on;
	logic [2:0]  overall_state;
	logic [2:0]  left_state;
	logic [2:0]  right_state;
	logic        rainy;
	logic        queue_overflow;
	logic        last;

	modport source (
		output valid, switch_valid, switch_address, switch_on, overall_state, left_state,
		       right_state, rainy, queue_overflow, last,
		input  ready
	);
	modport sink (
		input  valid, switch_valid, switch_address, switch_on, overall_state, left_state,
		       right_state, rainy, queue_overflow, last,
		output ready
	);
endinterface

// ----- rtl/core/two_side_slit_controller.sv -----
// Two-sided slit controller: request queues, reply decode and tick scheduling.
//
//  channel   | dir | handshake   | payload
//  ----------+-----+-------------+------------------------------------------------
//  req       | in  | valid/ready | operation, open_period, reply_code, status bytes
//  rsp       | out | valid/ready | switch command, side/combined states, flags, last
//  cfg       | in  | write only  | fail_limit (4 bits), written when cfg_wr_en high
//
//  A transaction lands in the input register, is processed into the two-slot result
//  buffer, and its first result is visible the cycle after it is processed.
//  One result per transaction; a tick that switches both sides gives two.
//  The result buffer drains one result per cycle while rsp is ready, and a
//  transaction is processed once the buffer will be empty, so a new one can be
//  processed as the last result leaves. A stalled rsp holds the buffer, then the
//  input register, then req. arst_n clears all control state; queue entries carry no reset.
module two_side_slit_controller
	import tssc_pkg::*;
#(
	parameter int QUEUE_DEPTH = TSSC_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [3:0]    cfg_wr_data,
	tssc_req_if.sink      req,
	tssc_rsp_if.source    rsp
);

	`include "two_side_slit_controller_macros.svh"

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C1 = CW'(QUEUE_DEPTH - 1);

	// wrap an index sum that stays below twice the depth
	function automatic logic [QW-1:0] wrap_idx(input logic [CW:0] v);
		if (v >= DEPTH_X) begin
			return QW'(v - DEPTH_X);
		end
		return QW'(v);
	endfunction

	// ---------------- configuration ----------------
	logic [3:0] fail_limit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= FAIL_LIMIT_RST;
		end else if (cfg_wr_en) begin
			fail_limit_q <= cfg_wr_data;
		end
	end

	// ---------------- input register ----------------
	logic        valid_s1;
	op_t         op_s1;
	logic [15:0] period_s1;
	logic [1:0]  code_s1;
	logic [7:0]  rbyte_s1;
	logic [7:0]  lbyte_s1;
	logic [7:0]  wbyte_s1;

	logic       process;
	logic       pop;
	logic [1:0] res_cnt_q;
	logic       req_take;

	assign req.ready = !valid_s1 || process;
	assign req_take  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s1     <= op_t'(req.operation);
			period_s1 <= req.open_period;
			code_s1   <= req.reply_code;
			rbyte_s1  <= req.right_byte;
			lbyte_s1  <= req.left_byte;
			wbyte_s1  <= req.rain_byte;
		end
	end

	// ---------------- architectural state ----------------
	slit_st_t      st_q   [3];
	cmd_t          cmd_q  [2];
	cmd_t          q_mem  [2][QUEUE_DEPTH];
	logic [QW-1:0] head_q [2];
	logic [CW-1:0] cnt_q  [2];
	logic [15:0]   sec_q  [2];
	logic [15:0]   held_q;
	logic [3:0]    fc_q;
	logic          rain_q;

	slit_st_t      st_n   [3];
	cmd_t          cmd_n  [2];
	logic [QW-1:0] head_n [2];
	logic [CW-1:0] cnt_n  [2];
	logic [15:0]   sec_n  [2];
	logic [15:0]   held_n;
	logic [3:0]    fc_n;
	logic          rain_n;

	// queue writes: up to two pushes per side per transaction
	logic          wa_en  [2];
	logic          wb_en  [2];
	logic [QW-1:0] wa_pos [2];
	logic [QW-1:0] wb_pos [2];
	cmd_t          wa_cmd [2];
	cmd_t          wb_cmd [2];

	logic [3:0] fc_inc;
	assign fc_inc = (fc_q == FAIL_CNT_MAX) ? FAIL_CNT_MAX : fc_q + 4'd1;

	// tick results per side
	logic        sw_v    [2];
	logic        sw_on   [2];
	logic [15:0] sw_addr [2];

	result_t    r0;
	result_t    r1;
	logic [1:0] res_n;

	always_comb begin
		logic [1:0]  push_n;
		cmd_t        pa;
		cmd_t        pb;
		logic        ok_a;
		logic        ok_b;
		logic        ovf;
		logic [15:0] sinc;
		cmd_t        new_cmd;
		cmd_t        last_cmd;
		cmd_t        ref_cmd;
		logic [7:0]  x;

		push_n   = 2'd0;
		pa       = CMD_STOP;
		pb       = CMD_STOP;
		ok_a     = 1'b0;
		ok_b     = 1'b0;
		sinc     = '0;
		new_cmd  = CMD_NONE;
		last_cmd = CMD_NONE;
		ref_cmd  = CMD_NONE;
		x        = '0;

		for (int i = 0; i < 3; i++) begin
			st_n[i] = st_q[i];
		end
		for (int i = 0; i < 2; i++) begin
			cmd_n[i]   = cmd_q[i];
			head_n[i]  = head_q[i];
			cnt_n[i]   = cnt_q[i];
			sec_n[i]   = sec_q[i];
			wa_en[i]   = 1'b0;
			wb_en[i]   = 1'b0;
			wa_pos[i]  = wrap_idx({1'b0, cnt_q[i]} + (CW + 1)'(head_q[i]));
			wb_pos[i]  = wrap_idx({1'b0, cnt_q[i]} + (CW + 1)'(head_q[i]) + (CW + 1)'(1));
			wa_cmd[i]  = CMD_STOP;
			wb_cmd[i]  = CMD_STOP;
			sw_v[i]    = 1'b0;
			sw_on[i]   = 1'b0;
			sw_addr[i] = '0;
		end
		held_n = held_q;
		fc_n   = fc_q;
		rain_n = rain_q;
		ovf    = 1'b0;

		unique case (op_s1) inside
			OP_OPEN, OP_CLOSE, OP_STOP: begin
				if (op_s1 == OP_OPEN) begin
					held_n = period_s1;
				end
				for (int i = 0; i < 2; i++) begin
					push_n = 2'd0;
					pa     = CMD_STOP;
					pb     = CMD_STOP;
					if (op_s1 == OP_OPEN) begin
						if (st_q[i] != ST_FULLY && st_q[i] != ST_OPENING) begin
							if (st_q[i] == ST_CLOSING) begin
								push_n = 2'd2;
								pb     = CMD_OPEN;
							end else begin
								push_n = 2'd1;
								pa     = CMD_OPEN;
							end
						end
					end else if (op_s1 == OP_CLOSE) begin
						if (st_q[i] != ST_CLOSED && st_q[i] != ST_CLOSING) begin
							if (st_q[i] == ST_OPENING) begin
								push_n = 2'd2;
								pb     = CMD_CLOSE;
							end else begin
								push_n = 2'd1;
								pa     = CMD_CLOSE;
							end
						end
					end else begin
						push_n = 2'd1;
					end
					ok_a = (push_n != 2'd0) && (cnt_q[i] < DEPTH_C);
					ok_b = (push_n == 2'd2) && (cnt_q[i] < DEPTH_C1);
					if ((push_n != 2'd0 && !ok_a) || (push_n == 2'd2 && !ok_b)) begin
						ovf = 1'b1;
					end
					wa_en[i]  = ok_a;
					wb_en[i]  = ok_b;
					wa_cmd[i] = pa;
					wb_cmd[i] = pb;
					cnt_n[i]  = cnt_q[i] + CW'(ok_a) + CW'(ok_b);
				end
			end
			OP_REPLY: begin
				if (code_s1 == RC_FAIL) begin
					fc_n = fc_inc;
					if (fc_inc >= fail_limit_q && st_q[SIDE_R] != ST_ERROR) begin
						for (int i = 0; i < 3; i++) begin
							st_n[i] = ST_ERROR;
						end
					end
				end else begin
					fc_n = '0;
					if (code_s1 == RC_STATUS) begin
						for (int i = 0; i < 2; i++) begin
							x = (i == SIDE_R) ? rbyte_s1 : lbyte_s1;
							if (x != BYTE_MOVING) begin
								cmd_n[i] = CMD_NONE;
								st_n[i]  = (x == BYTE_FULLY) ? ST_FULLY : ST_CLOSED;
							end else begin
								case (cmd_q[i])
									CMD_NONE:  st_n[i] = ST_PARTLY;
									CMD_OPEN:  st_n[i] = ST_OPENING;
									CMD_CLOSE: st_n[i] = ST_CLOSING;
									default:   cmd_n[i] = CMD_NONE;
								endcase
							end
						end
						if (st_n[SIDE_L] == st_n[SIDE_R] || cmd_n[SIDE_L] != CMD_NONE) begin
							st_n[SIDE_ALL] = st_n[SIDE_L];
						end else begin
							st_n[SIDE_ALL] = st_n[SIDE_R];
						end
						rain_n = (wbyte_s1 == BYTE_FULLY);
					end
				end
			end
			OP_TICK: begin
				for (int i = 0; i < 2; i++) begin
					last_cmd = cmd_q[i];
					new_cmd  = CMD_NONE;
					sinc     = (sec_q[i] == SEC_MAX) ? SEC_MAX : sec_q[i] + 16'd1;
					sec_n[i] = sinc;
					if (last_cmd == CMD_OPEN && held_q != '0 && sinc >= held_q) begin
						new_cmd = CMD_STOP;
					end else if (cnt_q[i] != '0) begin
						new_cmd   = q_mem[i][head_q[i]];
						head_n[i] = wrap_idx((CW + 1)'(head_q[i]) + (CW + 1)'(1));
						cnt_n[i]  = cnt_q[i] - CW'(1);
					end
					if (new_cmd == CMD_STOP && (last_cmd == CMD_NONE || last_cmd == CMD_STOP)) begin
						new_cmd = CMD_NONE;
					end
					if (new_cmd != CMD_NONE) begin
						sw_on[i]   = (new_cmd == CMD_OPEN || new_cmd == CMD_CLOSE);
						ref_cmd    = sw_on[i] ? new_cmd : last_cmd;
						sw_addr[i] = coil_addr(i == SIDE_L, ref_cmd == CMD_OPEN);
						sw_v[i]    = 1'b1;
						sec_n[i]   = '0;
						cmd_n[i]   = new_cmd;
					end
				end
			end
			default: begin
				// unused operation codes: status only
			end
		endcase

		// results carry the state after this transaction
		r0.switch_valid   = 1'b0;
		r0.switch_address = '0;
		r0.switch_on      = 1'b0;
		r0.overall_state  = st_n[SIDE_ALL];
		r0.left_state     = st_n[SIDE_L];
		r0.right_state    = st_n[SIDE_R];
		r0.rainy          = rain_n;
		r0.queue_overflow = ovf;
		r0.last           = 1'b1;
		r1                = r0;
		r1.switch_valid   = 1'b1;
		r1.switch_address = sw_addr[SIDE_L];
		r1.switch_on      = sw_on[SIDE_L];
		res_n             = 2'd1;
		if (sw_v[SIDE_R]) begin
			r0.switch_valid   = 1'b1;
			r0.switch_address = sw_addr[SIDE_R];
			r0.switch_on      = sw_on[SIDE_R];
			r0.last           = !sw_v[SIDE_L];
			if (sw_v[SIDE_L]) begin
				res_n = 2'd2;
			end
		end else if (sw_v[SIDE_L]) begin
			r0 = r1;
		end
	end

	// state update, only when the transaction is actually processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				st_q[i] <= ST_ERROR;
			end
			for (int i = 0; i < 2; i++) begin
				cmd_q[i]  <= CMD_NONE;
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				sec_q[i]  <= '0;
			end
			held_q <= '0;
			fc_q   <= '0;
			rain_q <= 1'b0;
		end else if (process) begin
			st_q   <= st_n;
			cmd_q  <= cmd_n;
			head_q <= head_n;
			cnt_q  <= cnt_n;
			sec_q  <= sec_n;
			held_q <= held_n;
			fc_q   <= fc_n;
			rain_q <= rain_n;
		end
	end

	// request queues, no reset: an entry is read only after it was pushed
	always_ff @(posedge clk) begin
		if (process) begin
			for (int i = 0; i < 2; i++) begin
				if (wa_en[i]) begin
					q_mem[i][wa_pos[i]] <= wa_cmd[i];
				end
				if (wb_en[i]) begin
					q_mem[i][wb_pos[i]] <= wb_cmd[i];
				end
			end
		end
	end

	// ---------------- result buffer ----------------
	// slot 0 is always the head; slot 1 moves down when slot 0 is taken
	result_t res_q [2];

	assign pop     = rsp.valid && rsp.ready;
	assign process = valid_s1 && (res_cnt_q == 2'd0 || (res_cnt_q == 2'd1 && pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (process) begin
			res_cnt_q <= res_n;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			res_q[0] <= r0;
			res_q[1] <= r1;
		end else if (pop) begin
			res_q[0] <= res_q[1];
		end
	end

	assign rsp.valid          = (res_cnt_q != 2'd0);
	assign rsp.switch_valid   = res_q[0].switch_valid;
	assign rsp.switch_address = res_q[0].switch_address;
	assign rsp.switch_on      = res_q[0].switch_on;
	assign rsp.overall_state  = res_q[0].overall_state;
	assign rsp.left_state     = res_q[0].left_state;
	assign rsp.right_state    = res_q[0].right_state;
	assign rsp.rainy          = res_q[0].rainy;
	assign rsp.queue_overflow = res_q[0].queue_overflow;
	assign rsp.last           = res_q[0].last;

	// ---------------- checks ----------------
	`TSSC_ASSERT_NXT(a_two_result_first_not_last, clk, arst_n, process && res_n == 2'd2, rsp.valid && !rsp.last && rsp.switch_valid)
	`TSSC_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, cnt_q[SIDE_R] <= DEPTH_C && cnt_q[SIDE_L] <= DEPTH_C)
	`TSSC_ASSERT_IMP(a_switch_addr_set, clk, arst_n, rsp.valid && rsp.switch_valid, rsp.switch_address != 16'd0)
	`TSSC_ASSERT_NXT(a_fail_to_error, clk, arst_n, process && op_s1 == OP_REPLY && code_s1 == RC_FAIL && fc_inc >= fail_limit_q, st_q[SIDE_R] == ST_ERROR && st_q[SIDE_ALL] == ST_ERROR)

endmodule
